### hdl/ir_pulse_width_symbol_decoder_defines.svh
// Assertion helpers used by the checker file of this block.
`ifndef IR_PULSE_WIDTH_SYMBOL_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_SYMBOL_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IPWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IPWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ipwd_pkg.sv
package ipwd_pkg;

    // APB address width: seven 32-bit registers at 4*i
    localparam int CFG_ADDR_W = 5;

    // default depth of the queue between classifier and decoder
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        REG_TICK_SCALE  = 3'd0,
        REG_LEADER_LOW  = 3'd1,
        REG_LEADER_HIGH = 3'd2,
        REG_SEP_LOW     = 3'd3,
        REG_SEP_HIGH    = 3'd4,
        REG_ONE_HIGH    = 3'd5,
        REG_ZERO_HIGH   = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        KIND_LEADER = 3'd0,
        KIND_SEP    = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_BAD    = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    localparam logic [7:0] SYM_LEADER = 8'd76;
    localparam logic [7:0] SYM_SEP    = 8'd83;
    localparam logic [7:0] SYM_ERR    = 8'hff;
    localparam logic [7:0] COUNT_MAX  = 8'hff;
    localparam logic [2:0] BIT_LAST   = 3'd7;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [15:0] tick_scale;
        logic [31:0] leader_low_win;
        logic [31:0] leader_high_win;
        logic [31:0] sep_low_win;
        logic [31:0] sep_high_win;
        logic [31:0] one_high_win;
        logic [31:0] zero_high_win;
    } cfg_t;

    // window hits of one pulse pair, plus the frame end mark
    typedef struct packed {
        logic leader_lo;
        logic leader_hi;
        logic sep_lo;
        logic sep_hi;
        logic one_hi;
        logic zero_hi;
        logic last;
    } pair_class_t;

endpackage

### hdl/ipwd_channels.sv
// input channel: one captured pulse pair per item
interface ipwd_pair_if;
    logic        valid;
    logic        ready;
    logic [15:0] low_time;
    logic [15:0] high_time;
    logic        last_pair;

    modport source (output valid, low_time, high_time, last_pair, input ready);
    modport sink   (input valid, low_time, high_time, last_pair, output ready);
endinterface

// output channel: one decoded symbol per item
interface ipwd_sym_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       frame_error;
    logic [7:0] symbol_count;
    logic       frame_last;

    modport source (output valid, kind, value, frame_error, symbol_count, frame_last,
                    input ready);
    modport sink   (input valid, kind, value, frame_error, symbol_count, frame_last,
                    output ready);
endinterface

### hdl/ipwd_regs.sv
module ipwd_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ipwd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output ipwd_pkg::cfg_t                  cfg
);

    // tick scale 1, all windows 0
    localparam ipwd_pkg::cfg_t CFG_RESET = {16'd1, 192'd0};

    ipwd_pkg::cfg_t   cfg_reg;
    ipwd_pkg::cfg_t   cfg_next;
    ipwd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = ipwd_pkg::reg_idx_t'(paddr[ipwd_pkg::CFG_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ipwd_pkg::REG_TICK_SCALE:  cfg_next.tick_scale      = pwdata[15:0];
                ipwd_pkg::REG_LEADER_LOW:  cfg_next.leader_low_win  = pwdata;
                ipwd_pkg::REG_LEADER_HIGH: cfg_next.leader_high_win = pwdata;
                ipwd_pkg::REG_SEP_LOW:     cfg_next.sep_low_win     = pwdata;
                ipwd_pkg::REG_SEP_HIGH:    cfg_next.sep_high_win    = pwdata;
                ipwd_pkg::REG_ONE_HIGH:    cfg_next.one_high_win    = pwdata;
                ipwd_pkg::REG_ZERO_HIGH:   cfg_next.zero_high_win   = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            ipwd_pkg::REG_TICK_SCALE:  prdata = {16'd0, cfg_reg.tick_scale};
            ipwd_pkg::REG_LEADER_LOW:  prdata = cfg_reg.leader_low_win;
            ipwd_pkg::REG_LEADER_HIGH: prdata = cfg_reg.leader_high_win;
            ipwd_pkg::REG_SEP_LOW:     prdata = cfg_reg.sep_low_win;
            ipwd_pkg::REG_SEP_HIGH:    prdata = cfg_reg.sep_high_win;
            ipwd_pkg::REG_ONE_HIGH:    prdata = cfg_reg.one_high_win;
            ipwd_pkg::REG_ZERO_HIGH:   prdata = cfg_reg.zero_high_win;
            default:                   prdata = '0;
        endcase
    end

endmodule

### hdl/ipwd_front.sv
module ipwd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipwd_pkg::cfg_t         cfg,
    ipwd_pair_if.sink              pairs,
    output logic                   push,
    output ipwd_pkg::pair_class_t  push_item,
    input  logic                   q_full
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic        last_reg;
    logic [31:0] lo_prod;
    logic [31:0] hi_prod;
    logic [15:0] lo_sat;
    logic [15:0] hi_sat;
    logic        accept;

    // inclusive window test: min in bits 15:0, max in bits 31:16
    function automatic logic in_win(input logic [15:0] v, input logic [31:0] w);
        return (v >= w[15:0]) && (v <= w[31:16]);
    endfunction

    // tick scaling with saturation to 16 bits
    assign lo_prod = 32'(pairs.low_time) * 32'(cfg.tick_scale);
    assign hi_prod = 32'(pairs.high_time) * 32'(cfg.tick_scale);
    assign lo_sat  = (lo_prod[31:16] != 16'd0) ? 16'hffff : lo_prod[15:0];
    assign hi_sat  = (hi_prod[31:16] != 16'd0) ? 16'hffff : hi_prod[15:0];

    assign pairs.ready = !s1_valid_reg || !q_full;
    assign accept      = pairs.valid && pairs.ready;
    assign push        = s1_valid_reg && !q_full;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg   <= lo_sat;
            hi_reg   <= hi_sat;
            last_reg <= pairs.last_pair;
        end
    end

    // window classification of the scaled pair
    always_comb
    begin
        push_item.leader_lo = in_win(lo_reg, cfg.leader_low_win);
        push_item.leader_hi = in_win(hi_reg, cfg.leader_high_win);
        push_item.sep_lo    = in_win(lo_reg, cfg.sep_low_win);
        push_item.sep_hi    = in_win(hi_reg, cfg.sep_high_win);
        push_item.one_hi    = in_win(hi_reg, cfg.one_high_win);
        push_item.zero_hi   = in_win(hi_reg, cfg.zero_high_win);
        push_item.last      = last_reg;
    end

endmodule

### hdl/ipwd_queue.sv
module ipwd_queue #(
    parameter int DEPTH = ipwd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ipwd_pkg::pair_class_t push_item,
    output logic                  full,
    input  logic                  pop,
    output ipwd_pkg::pair_class_t pop_item,
    output logic                  q_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipwd_pkg::pair_class_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### hdl/ipwd_back.sv
module ipwd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  ipwd_pkg::pair_class_t q_item,
    output logic                  pop,
    ipwd_sym_if.source            symbols
);

    // frame state
    logic        in_byte_reg;
    logic        in_byte_next;
    logic [2:0]  bit_cnt_reg;
    logic [2:0]  bit_cnt_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    logic        err_reg;
    logic        err_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;

    // output stage
    logic        out_valid_reg;
    logic        out_valid_next;
    ipwd_pkg::kind_t kind_reg;
    logic [7:0]  value_reg;
    logic        ferr_reg;
    logic [7:0]  scount_reg;
    logic        flast_reg;

    // per-item decode results
    logic        emit;
    logic        show;
    ipwd_pkg::kind_t kind_c;
    logic [7:0]  value_c;
    logic        res_err;
    logic [7:0]  res_count;
    logic [7:0]  base;
    logic [7:0]  bit_shift;
    logic        bit_err;

    assign pop = q_valid && (!out_valid_reg || symbols.ready);

    always_comb
    begin
        in_byte_next = in_byte_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        err_next     = err_reg;
        emit         = 1'b0;
        kind_c       = ipwd_pkg::KIND_END;
        value_c      = 8'd0;

        // next byte value if this pair is taken as a bit
        base    = in_byte_reg ? shift_reg : 8'd0;
        bit_err = !q_item.one_hi && !q_item.zero_hi;
        if (q_item.one_hi)
            bit_shift = {base[6:0], 1'b1};
        else if (q_item.zero_hi)
            bit_shift = {base[6:0], 1'b0};
        else
            bit_shift = ipwd_pkg::SYM_ERR;

        if (in_byte_reg)
        begin
            shift_next = bit_shift;
            if (bit_err)
                err_next = 1'b1;
            if (bit_cnt_reg == ipwd_pkg::BIT_LAST)
            begin
                emit         = 1'b1;
                kind_c       = ipwd_pkg::KIND_DATA;
                value_c      = bit_shift;
                in_byte_next = 1'b0;
                bit_cnt_next = 3'd0;
            end
            else
            begin
                bit_cnt_next = bit_cnt_reg + 3'd1;
            end
        end
        else if (q_item.leader_lo)
        begin
            emit = 1'b1;
            if (q_item.leader_hi)
            begin
                kind_c  = ipwd_pkg::KIND_LEADER;
                value_c = ipwd_pkg::SYM_LEADER;
            end
            else
            begin
                kind_c   = ipwd_pkg::KIND_BAD;
                value_c  = ipwd_pkg::SYM_ERR;
                err_next = 1'b1;
            end
        end
        else if (q_item.sep_lo)
        begin
            if (q_item.sep_hi)
            begin
                emit    = 1'b1;
                kind_c  = ipwd_pkg::KIND_SEP;
                value_c = ipwd_pkg::SYM_SEP;
            end
            else
            begin
                // byte starts, this pair is its top bit
                in_byte_next = 1'b1;
                shift_next   = bit_shift;
                bit_cnt_next = 3'd1;
                if (bit_err)
                    err_next = 1'b1;
            end
        end

        if (emit && (count_reg != ipwd_pkg::COUNT_MAX))
            count_next = count_reg + 8'd1;
        else
            count_next = count_reg;

        res_err   = err_next;
        res_count = count_next;
        show      = emit || q_item.last;

        // frame end clears the per-frame state
        if (q_item.last)
        begin
            in_byte_next = 1'b0;
            bit_cnt_next = 3'd0;
            shift_next   = 8'd0;
            err_next     = 1'b0;
            count_next   = 8'd0;
        end
    end

    always_comb
    begin
        if (pop)
            out_valid_next = show;
        else if (symbols.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_byte_reg   <= 1'b0;
            bit_cnt_reg   <= 3'd0;
            shift_reg     <= 8'd0;
            err_reg       <= 1'b0;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                in_byte_reg <= in_byte_next;
                bit_cnt_reg <= bit_cnt_next;
                shift_reg   <= shift_next;
                err_reg     <= err_next;
                count_reg   <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && show)
        begin
            kind_reg   <= kind_c;
            value_reg  <= value_c;
            ferr_reg   <= res_err;
            scount_reg <= res_count;
            flast_reg  <= q_item.last;
        end
    end

    assign symbols.valid        = out_valid_reg;
    assign symbols.kind         = kind_reg;
    assign symbols.value        = value_reg;
    assign symbols.frame_error  = ferr_reg;
    assign symbols.symbol_count = scount_reg;
    assign symbols.frame_last   = flast_reg;

endmodule

### hdl/ir_pulse_width_symbol_decoder.sv
// IR pulse-pair symbol decoder.
// pairs:   input channel, one captured pulse pair (low_time, high_time in ticks,
//          last_pair) per item, valid/ready handshake.
// symbols: output channel, zero or one decoded symbol per pair (kind, value,
//          frame_error, symbol_count, frame_last).
// APB port: seven 32-bit registers at 4*i (tick scale, then six min/max
//          windows); write only while the block is idle. pready is tied high.
// Path: an accepted pair passes the scale stage register, the queue and
//          the decode/output register before its symbol shows on the output.
// Throughput: one pair per cycle while the queue is not full; the scale
//          multiply is combinational and the decoder updates its state on each pop.
// A small queue sits between the classifier and the decoder. When the
//          receiver stalls, the held symbol stays put, the queue fills, and
//          only then does pairs.ready drop.
// Reset: registers return to their defaults (tick scale 1, windows 0), frame
//          state is cleared, queue and output stage are empty.
module ir_pulse_width_symbol_decoder #(
    parameter int QUEUE_DEPTH = ipwd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ipwd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    ipwd_pair_if.sink                       pairs,
    ipwd_sym_if.source                      symbols
);

    ipwd_pkg::cfg_t        cfg;
    ipwd_pkg::pair_class_t push_item;
    ipwd_pkg::pair_class_t pop_item;
    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_valid;

    ipwd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipwd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pairs     (pairs),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    ipwd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_valid   (q_valid)
    );

    ipwd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .pop     (pop),
        .symbols (symbols)
    );

endmodule

### hdl/ipwd_checker.sv
`include "ir_pulse_width_symbol_decoder_defines.svh"

module ipwd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       sym_valid,
    input logic       sym_ready,
    input logic [2:0] kind,
    input logic [7:0] value,
    input logic       frame_error,
    input logic       frame_last
);

    // a stalled symbol is not withdrawn
    `IPWD_ASSERT_NEXT(a_hold_valid, sym_valid && !sym_ready, sym_valid, "symbol dropped while stalled")

    // a bare frame-end result only comes on the last pair
    `IPWD_ASSERT_NOW(a_end_is_last, sym_valid && (kind == ipwd_pkg::KIND_END), frame_last, "frame end without frame_last")

    // a bad leader is reported as error byte with the sticky flag up
    `IPWD_ASSERT_NOW(a_bad_leader, sym_valid && (kind == ipwd_pkg::KIND_BAD), frame_error && (value == ipwd_pkg::SYM_ERR), "bad leader without error flag or byte")

    // leader and separator carry their fixed symbol bytes
    `IPWD_ASSERT_NOW(a_fixed_sym, sym_valid && ((kind == ipwd_pkg::KIND_LEADER) || (kind == ipwd_pkg::KIND_SEP)), (value == ipwd_pkg::SYM_LEADER) || (value == ipwd_pkg::SYM_SEP), "leader or separator with wrong byte")

endmodule

bind ir_pulse_width_symbol_decoder ipwd_checker u_ipwd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .sym_valid   (symbols.valid),
    .sym_ready   (symbols.ready),
    .kind        (symbols.kind),
    .value       (symbols.value),
    .frame_error (symbols.frame_error),
    .frame_last  (symbols.frame_last)
);
